[rtl/core/btfc_pkg.sv]
// btfc_pkg: shared types and constants of the boundary-tag free engine
// holds action codes, header flag constants, controller states and the
// command and status structs between controller and datapath; no dependencies
package btfc_pkg;

   // request action codes
   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_READ  = 2'd1,
      ACT_FREE  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // header flag masks and the end mark
   localparam logic [31:0] BUSY_MASK      = 32'h0000_0001;
   localparam logic [31:0] PREV_BUSY_MASK = 32'h0000_0002;
   localparam logic [31:0] END_MARK       = 32'h0000_0001;

   // controller states, one-hot
   typedef enum logic [12:0] {
      ST_IDLE     = 13'h0001,
      ST_RD_DATA  = 13'h0002,
      ST_F_HDR    = 13'h0004,
      ST_F_NXT_RD = 13'h0008,
      ST_F_NXT    = 13'h0010,
      ST_F_FOL_RD = 13'h0020,
      ST_F_FOL    = 13'h0040,
      ST_F_HD2_RD = 13'h0080,
      ST_F_HD2    = 13'h0100,
      ST_F_PSZ    = 13'h0200,
      ST_F_PHDR   = 13'h0400,
      ST_F_FTR    = 13'h0800,
      ST_DONE     = 13'h1000
   } state_type;

   // heap byte address sources
   typedef enum logic [2:0] {
      ADDR_REQ       = 3'd0,
      ADDR_START     = 3'd1,
      ADDR_BLK       = 3'd2,
      ADDR_NEXT      = 3'd3,
      ADDR_BLK_M4    = 3'd4,
      ADDR_PREV_CALC = 3'd5,
      ADDR_PREV      = 3'd6,
      ADDR_FOOTER    = 3'd7
   } addr_sel_type;

   // heap write data sources
   typedef enum logic [2:0] {
      WD_REQ       = 3'd0,
      WD_CLR_BUSY  = 3'd1,
      WD_ADD_NEXT  = 3'd2,
      WD_CLR_PREV  = 3'd3,
      WD_ADD_HDR   = 3'd4,
      WD_SIZE      = 3'd5
   } wdata_sel_type;

   typedef struct packed {
      logic          start;
      logic          mem_rd;
      logic          mem_wr;
      addr_sel_type  addr_sel;
      wdata_sel_type wd_sel;
      logic          hdr_ld_wdata;
      logic          hdr_ld_rdata;
      logic          prev_ld;
      logic          blk_ld_prev;
      logic          set_merge_next;
      logic          set_merge_prev;
      logic          res_ld;
      logic          out_ld;
   } dp_cmd_type;

   typedef struct packed {
      logic rd_busy;
      logic rd_prev_busy;
      logic rd_end_mark;
   } dp_status_type;

endpackage

[rtl/core/btfc_ram.sv]
// btfc_ram: generic single-port word memory with registered read
// one access per cycle, write or read; no dependencies
module btfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write, or registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/btfc_dpath.sv]
// btfc_dpath: address and data path of the free engine
// block, header and previous-block registers, heap address and write data
// selection, result and response registers; uses btfc_pkg
module btfc_dpath import btfc_pkg::*; #(
   parameter int HEAP_BYTES = 4096,
   parameter int FLAG_BITS  = 3
) (
   input  logic                                clock,
   input  dp_cmd_type                          cmd,
   output dp_status_type                       status,
   input  logic [11:0]                         req_address,
   input  logic [31:0]                         req_write_data,
   output logic                                mem_en,
   output logic                                mem_we,
   output logic [$clog2(HEAP_BYTES/4)-1:0]     mem_addr,
   output logic [31:0]                         mem_wdata,
   input  logic [31:0]                         mem_rdata,
   output logic [31:0]                         rsp_read_data,
   output logic [1:0]                          rsp_merged
);

   // heap depth is a power of two, so word index wrap is a bit slice
   localparam int IDX_W  = $clog2(HEAP_BYTES / 4);
   localparam int ADDR_W = IDX_W + 2;
   localparam logic [31:0] FLAG_MASK = 32'((1 << FLAG_BITS) - 1);

   logic [ADDR_W-1:0] blk_ff, blk_in;
   logic [ADDR_W-1:0] prev_ff, prev_in;
   logic [31:0]       hdr_ff, hdr_in;
   logic [1:0]        merged_ff, merged_in;
   logic [31:0]       res_ff, res_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_merged_ff, rsp_merged_in;

   logic [ADDR_W-1:0] req_addr_ext;
   logic [ADDR_W-1:0] start_addr;
   logic [31:0]       hdr_size;
   logic [31:0]       rd_size;
   logic [ADDR_W-1:0] hdr_size_a;
   logic [ADDR_W-1:0] next_addr;
   logic [ADDR_W-1:0] prev_calc;
   logic [ADDR_W-1:0] byte_addr;

   // address arithmetic, wrapping inside the heap
   assign req_addr_ext = ADDR_W'(req_address);
   assign start_addr   = req_addr_ext - ADDR_W'(4);
   assign hdr_size     = hdr_ff & ~FLAG_MASK;
   assign rd_size      = mem_rdata & ~FLAG_MASK;
   assign hdr_size_a   = hdr_size[ADDR_W-1:0];
   assign next_addr    = blk_ff + hdr_size_a;
   assign prev_calc    = blk_ff - mem_rdata[ADDR_W-1:0];

   // heap address select
   always_comb begin
      case (cmd.addr_sel)
         ADDR_REQ:       byte_addr = req_addr_ext;
         ADDR_START:     byte_addr = start_addr;
         ADDR_BLK:       byte_addr = blk_ff;
         ADDR_NEXT:      byte_addr = next_addr;
         ADDR_BLK_M4:    byte_addr = blk_ff - ADDR_W'(4);
         ADDR_PREV_CALC: byte_addr = prev_calc;
         ADDR_PREV:      byte_addr = prev_ff;
         ADDR_FOOTER:    byte_addr = next_addr - ADDR_W'(4);
         default:        byte_addr = blk_ff;
      endcase
   end

   // heap write data select
   always_comb begin
      case (cmd.wd_sel)
         WD_REQ:      mem_wdata = req_write_data;
         WD_CLR_BUSY: mem_wdata = mem_rdata & ~BUSY_MASK;
         WD_ADD_NEXT: mem_wdata = hdr_ff + rd_size;
         WD_CLR_PREV: mem_wdata = mem_rdata & ~PREV_BUSY_MASK;
         WD_ADD_HDR:  mem_wdata = mem_rdata + hdr_size;
         WD_SIZE:     mem_wdata = hdr_size;
         default:     mem_wdata = hdr_size;
      endcase
   end

   assign mem_en   = cmd.mem_rd | cmd.mem_wr;
   assign mem_we   = cmd.mem_wr;
   assign mem_addr = byte_addr[ADDR_W-1:2];

   // flags of the word just read
   assign status.rd_busy      = (mem_rdata & BUSY_MASK) != 32'd0;
   assign status.rd_prev_busy = (mem_rdata & PREV_BUSY_MASK) != 32'd0;
   assign status.rd_end_mark  = mem_rdata == END_MARK;

   // working registers
   always_comb begin
      blk_in        = blk_ff;
      prev_in       = prev_ff;
      hdr_in        = hdr_ff;
      merged_in     = merged_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_merged_in = rsp_merged_ff;
      if (cmd.start) begin
         blk_in    = start_addr;
         merged_in = 2'b00;
         res_in    = 32'd0;
      end
      if (cmd.hdr_ld_wdata) begin
         hdr_in = mem_wdata;
      end
      if (cmd.hdr_ld_rdata) begin
         hdr_in = mem_rdata;
      end
      if (cmd.prev_ld) begin
         prev_in = prev_calc;
      end
      if (cmd.blk_ld_prev) begin
         blk_in = prev_ff;
      end
      if (cmd.set_merge_next) begin
         merged_in[0] = 1'b1;
      end
      if (cmd.set_merge_prev) begin
         merged_in[1] = 1'b1;
      end
      if (cmd.res_ld) begin
         res_in = mem_rdata;
      end
      if (cmd.out_ld) begin
         rsp_data_in   = res_ff;
         rsp_merged_in = merged_ff;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff        <= blk_in;
      prev_ff       <= prev_in;
      hdr_ff        <= hdr_in;
      merged_ff     <= merged_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   assign rsp_read_data = rsp_data_ff;
   assign rsp_merged    = rsp_merged_ff;

endmodule

[rtl/core/btfc_ctrl.sv]
// btfc_ctrl: sequencer of the free engine
// steps each request through its heap accesses and owns the response valid;
// uses btfc_pkg
module btfc_ctrl import btfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_action,
   input  logic          req_addr_zero,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = state_ff == ST_IDLE;
   assign accept    = req_valid & req_ready;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.start = 1'b1;
               case (req_action)
                  ACT_WRITE: begin
                     cmd.mem_wr   = 1'b1;
                     cmd.addr_sel = ADDR_REQ;
                     cmd.wd_sel   = WD_REQ;
                     state_in     = ST_DONE;
                  end
                  ACT_READ: begin
                     cmd.mem_rd   = 1'b1;
                     cmd.addr_sel = ADDR_REQ;
                     state_in     = ST_RD_DATA;
                  end
                  ACT_FREE: begin
                     if (req_addr_zero) begin
                        state_in = ST_DONE;
                     end else begin
                        cmd.mem_rd   = 1'b1;
                        cmd.addr_sel = ADDR_START;
                        state_in     = ST_F_HDR;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_RD_DATA: begin
            cmd.res_ld = 1'b1;
            state_in   = ST_DONE;
         end
         // clear busy in the header
         ST_F_HDR: begin
            cmd.mem_wr       = 1'b1;
            cmd.addr_sel     = ADDR_BLK;
            cmd.wd_sel       = WD_CLR_BUSY;
            cmd.hdr_ld_wdata = 1'b1;
            state_in         = ST_F_NXT_RD;
         end
         ST_F_NXT_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_NEXT;
            state_in     = ST_F_NXT;
         end
         // merge a free next block
         ST_F_NXT: begin
            if (!status.rd_busy && !status.rd_end_mark) begin
               cmd.mem_wr         = 1'b1;
               cmd.addr_sel       = ADDR_BLK;
               cmd.wd_sel         = WD_ADD_NEXT;
               cmd.hdr_ld_wdata   = 1'b1;
               cmd.set_merge_next = 1'b1;
            end
            state_in = ST_F_FOL_RD;
         end
         ST_F_FOL_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_NEXT;
            state_in     = ST_F_FOL;
         end
         // clear previous-busy of the following block
         ST_F_FOL: begin
            if (!status.rd_end_mark) begin
               cmd.mem_wr   = 1'b1;
               cmd.addr_sel = ADDR_NEXT;
               cmd.wd_sel   = WD_CLR_PREV;
            end
            state_in = ST_F_HD2_RD;
         end
         ST_F_HD2_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_BLK;
            state_in     = ST_F_HD2;
         end
         // previous block free: fetch its size from the footer
         ST_F_HD2: begin
            cmd.hdr_ld_rdata = 1'b1;
            if (!status.rd_prev_busy) begin
               cmd.mem_rd   = 1'b1;
               cmd.addr_sel = ADDR_BLK_M4;
               state_in     = ST_F_PSZ;
            end else begin
               state_in = ST_F_FTR;
            end
         end
         ST_F_PSZ: begin
            cmd.prev_ld  = 1'b1;
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_PREV_CALC;
            state_in     = ST_F_PHDR;
         end
         // merge into a free previous block
         ST_F_PHDR: begin
            if (!status.rd_busy) begin
               cmd.mem_wr         = 1'b1;
               cmd.addr_sel       = ADDR_PREV;
               cmd.wd_sel         = WD_ADD_HDR;
               cmd.hdr_ld_wdata   = 1'b1;
               cmd.blk_ld_prev    = 1'b1;
               cmd.set_merge_prev = 1'b1;
            end
            state_in = ST_F_FTR;
         end
         // footer of the merged block
         ST_F_FTR: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADDR_FOOTER;
            cmd.wd_sel   = WD_SIZE;
            state_in     = ST_DONE;
         end
         // hand the result to the response register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_ld) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a nonzero free starts with the header fetch
   a_free_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_action == ACT_FREE && !req_addr_zero |=> state_ff == ST_F_HDR)
      else $error("free did not start with header fetch");

   // a result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten");

   // previous-size fetch only follows the second header read
   a_psz_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_F_PSZ |-> $past(state_ff) == ST_F_HD2)
      else $error("footer fetch out of order");

   // a response appears only out of the done state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done state");

endmodule

[rtl/core/boundary_tag_free_coalesce.sv]
// boundary_tag_free_coalesce: heap word store with a boundary-tag free engine
// a write or read is one heap access, a free of address zero none; other frees
// update header, next, following and free previous block and the footer; one
// item at a time, the next accepted the cycle after the result enters the
// response register; reset clears the sequencer and response valid; heap contents
// are kept as is and get no clearing pass; HEAP_BYTES must be a power of two
module boundary_tag_free_coalesce import btfc_pkg::*; #(
   parameter int HEAP_BYTES = 4096,
   parameter int FLAG_BITS  = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_address,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic [1:0]  rsp_merged
);

   localparam int WORDS = HEAP_BYTES / 4;
   localparam int IDX_W = $clog2(WORDS);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic              mem_en;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_addr;
   logic [31:0]       mem_wdata;
   logic [31:0]       mem_rdata;

   // sequencer
   btfc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_addr_zero (req_address == 12'd0),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .status        (status)
   );

   // datapath
   btfc_dpath #(
      .HEAP_BYTES (HEAP_BYTES),
      .FLAG_BITS  (FLAG_BITS)
   ) u_dpath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .mem_en         (mem_en),
      .mem_we         (mem_we),
      .mem_addr       (mem_addr),
      .mem_wdata      (mem_wdata),
      .mem_rdata      (mem_rdata),
      .rsp_read_data  (rsp_read_data),
      .rsp_merged     (rsp_merged)
   );

   // heap word memory
   btfc_ram #(
      .WIDTH (32),
      .DEPTH (WORDS)
   ) u_heap (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

endmodule
